@@ src/rhps_pkg.sv @@
// ----------------------------------------------------------------------------
// rhps_pkg
// Shared types, constants and the sequencer microcode for the ramp/hold
// profile setpoint block.
// ----------------------------------------------------------------------------
package rhps_pkg;

  // field widths
  localparam int KIND_W   = 2;
  localparam int LEN_W    = 16;
  localparam int TEMP_W   = 13;
  localparam int TIME_W   = 20;
  localparam int PLEN_W   = 19;
  localparam int CNT_W    = 4;
  localparam int SLOT_W   = 3;
  localparam int ELAPSE_W = 20;
  localparam int MUL_W    = TEMP_W + LEN_W;
  localparam int DIV_W    = MUL_W + 1;
  localparam int DCNT_W   = $clog2(DIV_W);
  localparam int PC_W     = 3;

  // default table depth
  localparam int MAX_SEGMENTS_DEF = 8;

  // constants of the profile
  localparam logic [TEMP_W-1:0] START_TEMP     = TEMP_W'(320);
  localparam logic [PLEN_W-1:0] DEFAULT_LENGTH = PLEN_W'(300);

  // command codes
  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_t;

  // segment kinds; the unused code behaves as hold
  typedef enum logic [KIND_W-1:0] {
    KIND_RAMP = 2'd0,
    KIND_HOLD = 2'd1,
    KIND_STEP = 2'd2,
    KIND_RSVD = 2'd3
  } kind_t;

  // input transaction
  typedef struct packed {
    cmd_t                command;
    logic [SLOT_W-1:0]   segment_slot;
    logic [KIND_W-1:0]   segment_kind;
    logic [LEN_W-1:0]    segment_length;
    logic [TEMP_W-1:0]   segment_goal;
    logic [TIME_W-1:0]   query_time;
  } item_t;

  // output transaction
  typedef struct packed {
    logic [TEMP_W-1:0] setpoint;
    logic [PLEN_W-1:0] profile_length;
  } result_t;

  // one table entry
  typedef struct packed {
    kind_t              kind;
    logic [LEN_W-1:0]   length;
    logic [TEMP_W-1:0]  goal;
  } seg_entry_t;

  localparam int ENTRY_W = $bits(seg_entry_t);

  // datapath operations
  typedef enum logic [2:0] {
    OP_IDLE,
    OP_INIT,
    OP_FETCH,
    OP_EVAL,
    OP_SETTLE,
    OP_MUL,
    OP_DIV,
    OP_ADJUST
  } op_t;

  // jump conditions
  typedef enum logic [2:0] {
    JMP_NEXT,
    JMP_ALWAYS,
    JMP_WALK_DONE,
    JMP_NO_DIV,
    JMP_DIV_MORE,
    JMP_END
  } jmp_t;

  typedef logic [PC_W-1:0] pc_t;

  typedef struct packed {
    op_t  op;
    jmp_t jmp;
    pc_t  target;
  } ctrl_word_t;

  // datapath flags seen by the sequencer
  typedef struct packed {
    logic walk_done;
    logic need_div;
    logic div_more;
  } status_t;

  // step addresses
  localparam pc_t STEP_INIT   = PC_W'(0);
  localparam pc_t STEP_FETCH  = PC_W'(1);
  localparam pc_t STEP_EVAL   = PC_W'(2);
  localparam pc_t STEP_SETTLE = PC_W'(3);
  localparam pc_t STEP_MUL    = PC_W'(4);
  localparam pc_t STEP_DIV    = PC_W'(5);
  localparam pc_t STEP_ADJUST = PC_W'(6);
  localparam pc_t STEP_EMIT   = PC_W'(7);

  localparam ctrl_word_t CTRL_IDLE = '{op: OP_IDLE, jmp: JMP_NEXT, target: STEP_INIT};

  // microcode program
  function automatic ctrl_word_t microcode(input pc_t pc);
    ctrl_word_t w;
    w = CTRL_IDLE;
    case (pc)
      STEP_INIT:   w = '{op: OP_INIT,   jmp: JMP_NEXT,      target: STEP_INIT};
      STEP_FETCH:  w = '{op: OP_FETCH,  jmp: JMP_WALK_DONE, target: STEP_SETTLE};
      STEP_EVAL:   w = '{op: OP_EVAL,   jmp: JMP_ALWAYS,    target: STEP_FETCH};
      STEP_SETTLE: w = '{op: OP_SETTLE, jmp: JMP_NO_DIV,    target: STEP_EMIT};
      STEP_MUL:    w = '{op: OP_MUL,    jmp: JMP_NEXT,      target: STEP_INIT};
      STEP_DIV:    w = '{op: OP_DIV,    jmp: JMP_DIV_MORE,  target: STEP_DIV};
      STEP_ADJUST: w = '{op: OP_ADJUST, jmp: JMP_NEXT,      target: STEP_INIT};
      STEP_EMIT:   w = '{op: OP_IDLE,   jmp: JMP_END,       target: STEP_INIT};
      default:     w = CTRL_IDLE;
    endcase
    return w;
  endfunction

endpackage

@@ src/rhps_ram.sv @@
// ----------------------------------------------------------------------------
// rhps_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module rhps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/rhps_seq.sv @@
// ----------------------------------------------------------------------------
// rhps_seq
// Microcode sequencer: step counter, control ROM and conditional jumps.
// ----------------------------------------------------------------------------
module rhps_seq
  import rhps_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       go,
  input  status_t    stat,
  output ctrl_word_t ctrl,
  output logic       emit,
  output logic       busy
);

  logic       running;
  pc_t        pc;
  ctrl_word_t word;
  logic       take;

  // control word lookup
  assign word = microcode(pc);
  assign ctrl = running ? word : CTRL_IDLE;
  assign emit = running && (word.jmp == JMP_END);
  assign busy = running;

  // jump condition select
  always_comb begin
    case (word.jmp)
      JMP_NEXT:      take = 1'b0;
      JMP_ALWAYS:    take = 1'b1;
      JMP_WALK_DONE: take = stat.walk_done;
      JMP_NO_DIV:    take = !stat.need_div;
      JMP_DIV_MORE:  take = stat.div_more;
      JMP_END:       take = 1'b1;
      default:       take = 1'b0;
    endcase
  end

  // step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      pc      <= STEP_INIT;
    end else if (go) begin
      running <= 1'b1;
      pc      <= STEP_INIT;
    end else if (running) begin
      if (word.jmp == JMP_END) begin
        running <= 1'b0;
      end
      pc <= take ? word.target : pc + PC_W'(1);
    end
  end

  // a transaction ends only through the last program step
  a_end_by_emit: assert property (@(posedge clk) disable iff (rst)
    $fell(running) |-> $past(pc == STEP_EMIT))
    else $error("sequencer stopped outside the emit step");

endmodule

@@ src/rhps_dp.sv @@
// ----------------------------------------------------------------------------
// rhps_dp
// Datapath: segment walk registers, ramp multiplier and restoring divider.
// ----------------------------------------------------------------------------
module rhps_dp
  import rhps_pkg::*;
#(
  parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF,
  parameter int AW           = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              go,
  input  logic [TIME_W-1:0] query_time,
  input  logic [CNT_W-1:0]  active,
  input  ctrl_word_t        ctrl,
  input  logic              emit,
  input  seg_entry_t        entry,
  output logic [AW-1:0]     raddr,
  output status_t           stat,
  output logic              done,
  output result_t           result
);

  logic [TIME_W-1:0]   t;
  logic [CNT_W-1:0]    idx;
  logic [ELAPSE_W-1:0] elapsed;
  logic [TEMP_W-1:0]   cur;
  logic                found;
  logic                need_div;
  logic [TEMP_W-1:0]   setpoint;
  logic [TEMP_W-1:0]   ramp_start;
  logic                ramp_down;
  logic [TEMP_W-1:0]   ramp_diff;
  logic [LEN_W-1:0]    ramp_u;
  logic [LEN_W-1:0]    div_len;
  logic [DIV_W-1:0]    dvd;
  logic [LEN_W-1:0]    rem;
  logic [DCNT_W-1:0]   div_cnt;

  logic [ELAPSE_W:0]   seg_end;
  logic                hit;
  logic [ELAPSE_W-1:0] into_seg;
  logic [MUL_W-1:0]    product;
  logic [LEN_W:0]      rem_sh;
  logic                rem_ge;

  // table read address follows the walk index
  assign raddr = AW'(idx);

  // status to the sequencer
  assign stat.walk_done = (idx == active);
  assign stat.need_div  = need_div;
  assign stat.div_more  = (div_cnt != '0);

  // boundary test for the entry being evaluated
  assign seg_end  = {1'b0, elapsed} + (ELAPSE_W + 1)'(entry.length);
  assign hit      = !found && ((ELAPSE_W + 1)'(t) <= seg_end);
  assign into_seg = ELAPSE_W'(t) - elapsed;

  // ramp product
  assign product = MUL_W'(ramp_diff) * MUL_W'(ramp_u);

  // one restoring divide step
  assign rem_sh = {rem, dvd[DIV_W-1]};
  assign rem_ge = (rem_sh >= {1'b0, div_len});

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      done     <= 1'b0;
      found    <= 1'b0;
      need_div <= 1'b0;
      idx      <= '0;
      div_cnt  <= '0;
    end else begin
      done <= emit;
      case (ctrl.op)
        OP_INIT: begin
          found    <= 1'b0;
          need_div <= 1'b0;
          idx      <= '0;
        end
        OP_EVAL: begin
          idx <= idx + CNT_W'(1);
          if (hit) begin
            found <= 1'b1;
            if (entry.kind == KIND_RAMP && entry.length != '0) begin
              need_div <= 1'b1;
            end
          end
        end
        OP_MUL: begin
          div_cnt <= DCNT_W'(DIV_W - 1);
        end
        OP_DIV: begin
          div_cnt <= div_cnt - DCNT_W'(1);
        end
        default: begin
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (go) begin
      t <= query_time;
    end
    case (ctrl.op)
      OP_INIT: begin
        elapsed <= '0;
        cur     <= START_TEMP;
      end
      OP_EVAL: begin
        elapsed <= elapsed + ELAPSE_W'(entry.length);
        cur     <= entry.goal;
        if (hit) begin
          setpoint   <= entry.goal;
          ramp_start <= cur;
          ramp_down  <= (entry.goal < cur);
          ramp_diff  <= (entry.goal < cur) ? cur - entry.goal : entry.goal - cur;
          ramp_u     <= into_seg[LEN_W-1:0];
          div_len    <= entry.length;
        end
      end
      OP_SETTLE: begin
        if (!found) begin
          setpoint <= cur;
        end
      end
      OP_MUL: begin
        // a falling ramp divides with ceiling so the value truncates down
        dvd <= DIV_W'(product) + (ramp_down ? DIV_W'(div_len - LEN_W'(1)) : '0);
        rem <= '0;
      end
      OP_DIV: begin
        rem <= rem_ge ? LEN_W'(rem_sh - {1'b0, div_len}) : rem_sh[LEN_W-1:0];
        dvd <= {dvd[DIV_W-2:0], rem_ge};
      end
      OP_ADJUST: begin
        setpoint <= ramp_down ? ramp_start - dvd[TEMP_W-1:0]
                              : ramp_start + dvd[TEMP_W-1:0];
      end
      default: begin
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (emit) begin
      result.setpoint       <= setpoint;
      result.profile_length <= (elapsed == '0) ? DEFAULT_LENGTH : elapsed[PLEN_W-1:0];
    end
  end

  // an entry is only evaluated while the walk is inside the table
  a_eval_in_range: assert property (@(posedge clk) disable iff (rst)
    (ctrl.op == OP_EVAL) |-> (idx < active))
    else $error("segment evaluated past the active count");

  // the ramp quotient fits in the temperature width
  a_quot_fits: assert property (@(posedge clk) disable iff (rst)
    (ctrl.op == OP_ADJUST) |-> (dvd[DIV_W-1:TEMP_W] == '0))
    else $error("ramp quotient out of range");

  // a result strobe lasts one cycle
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for more than one cycle");

endmodule

@@ src/ramp_hold_profile_setpoint.sv @@
// ----------------------------------------------------------------------------
// ramp_hold_profile_setpoint
// Temperature profile setpoint generator over a table of ramp, hold and
// step segments.
// ----------------------------------------------------------------------------
// A load transaction (command 0) writes one segment into the table and
// never raises busy; it gives no result. A query transaction (command 1)
// raises busy while a microcoded sequencer walks the active segments,
// with a table read and a compare for each segment, then returns the
// setpoint and profile length on result with a one-cycle done strobe.
// When a query lands inside a ramp of nonzero length, a bit-serial
// divider runs one quotient bit per cycle over 30 bits before the
// result is emitted. The receiver cannot stall: done and result are
// valid for one cycle only. segments_in_use may be written only while
// busy is low.
// ----------------------------------------------------------------------------
module ramp_hold_profile_setpoint
  import rhps_pkg::*;
#(
  parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  item_t            item,
  output logic             busy,
  input  logic             config_write,
  input  logic [CNT_W-1:0] config_data,
  output logic             done,
  output result_t          result
);

  localparam int AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;

  logic [CNT_W-1:0] segments_in_use;
  logic [CNT_W-1:0] active;
  logic             accept;
  logic             go;
  logic             load_we;
  seg_entry_t       load_entry;
  seg_entry_t       entry;
  logic [AW-1:0]    raddr;
  ctrl_word_t       ctrl;
  status_t          stat;
  logic             emit;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      segments_in_use <= '0;
    end else if (config_write) begin
      segments_in_use <= config_data;
    end
  end

  // active count saturates at the table depth
  assign active = (int'(segments_in_use) > MAX_SEGMENTS) ? CNT_W'(MAX_SEGMENTS)
                                                         : segments_in_use;

  // transaction decode
  assign accept  = start && !busy;
  assign go      = accept && (item.command == CMD_QUERY);
  assign load_we = accept && (item.command == CMD_LOAD)
                   && (int'(item.segment_slot) < MAX_SEGMENTS);

  assign load_entry.kind   = kind_t'(item.segment_kind);
  assign load_entry.length = item.segment_length;
  assign load_entry.goal   = item.segment_goal;

  // segment table
  rhps_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_SEGMENTS),
    .AW    (AW)
  ) u_table (
    .clk   (clk),
    .we    (load_we),
    .waddr (AW'(item.segment_slot)),
    .wdata (load_entry),
    .raddr (raddr),
    .rdata (entry)
  );

  // sequencer
  rhps_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .go   (go),
    .stat (stat),
    .ctrl (ctrl),
    .emit (emit),
    .busy (busy)
  );

  // datapath
  rhps_dp #(
    .MAX_SEGMENTS (MAX_SEGMENTS),
    .AW           (AW)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .go         (go),
    .query_time (item.query_time),
    .active     (active),
    .ctrl       (ctrl),
    .emit       (emit),
    .entry      (entry),
    .raddr      (raddr),
    .stat       (stat),
    .done       (done),
    .result     (result)
  );

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the ramp/hold profile setpoint block. Loads fill
// the segment table and queries are checked against a cycle-free predictor
// of the segment walk and ramp interpolation. The active segment count is
// reprogrammed between phases, and the sender idles at varying rates.
// ----------------------------------------------------------------------------
module testbench
  import rhps_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  item_t            item = '0;
  logic             busy;
  logic             config_write = 1'b0;
  logic [CNT_W-1:0] config_data = '0;
  logic             done;
  result_t          result;

  ramp_hold_profile_setpoint dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .item         (item),
    .busy         (busy),
    .config_write (config_write),
    .config_data  (config_data),
    .done         (done),
    .result       (result)
  );

  // clock, 2 ns period
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor state, tracks the table as transactions are accepted
  seg_entry_t       profile_table [MAX_SEGMENTS_DEF] = '{default: '0};
  logic [CNT_W-1:0] active_segments = '0;

  // stimulus side bookkeeping
  item_t       pending_items [$];
  result_t     expected_setpoints [$];
  int unsigned planned_length [MAX_SEGMENTS_DEF] = '{default: 0};
  int unsigned planned_count = 0;
  int unsigned sender_idle_pct = 0;
  bit          taken = 1'b0;
  int unsigned mismatch_count = 0;

  // setpoint and profile length for a query at time t
  function automatic result_t predict_setpoint(input logic [TIME_W-1:0] t);
    result_t         r;
    int unsigned     n;
    int unsigned     i;
    int unsigned     elapsed;
    int unsigned     cur;
    int unsigned     sum;
    int unsigned     len;
    int unsigned     goal;
    longint unsigned span;
    bit              found;
    n = (active_segments > CNT_W'(MAX_SEGMENTS_DEF)) ? MAX_SEGMENTS_DEF
                                                     : 32'(active_segments);
    elapsed = 0;
    cur = 32'(START_TEMP);
    sum = 0;
    found = 1'b0;
    r = '0;
    for (i = 0; i < n; i++) begin
      len = 32'(profile_table[i].length);
      goal = 32'(profile_table[i].goal);
      sum += len;
      if (!found && 32'(t) <= elapsed + len) begin
        found = 1'b1;
        if (profile_table[i].kind != KIND_RAMP || len == 0) begin
          r.setpoint = TEMP_W'(goal);
        end else if (goal >= cur) begin
          // rising ramp, truncate toward the start value
          span = 64'(goal - cur) * 64'(32'(t) - elapsed);
          r.setpoint = TEMP_W'(64'(cur) + span / 64'(len));
        end else begin
          // falling ramp, round the drop up so the value floors
          span = 64'(cur - goal) * 64'(32'(t) - elapsed);
          r.setpoint = TEMP_W'(64'(cur) - (span + 64'(len) - 64'd1) / 64'(len));
        end
      end
      elapsed += len;
      if (!found) cur = goal;
    end
    if (!found) r.setpoint = TEMP_W'(cur);
    r.profile_length = (sum == 0) ? DEFAULT_LENGTH : PLEN_W'(sum);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input result_t exp_r, input result_t act_r);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("[%0t] %s: expected setpoint %0d length %0d, got setpoint %0d length %0d",
               $realtime, what, exp_r.setpoint, exp_r.profile_length,
               act_r.setpoint, act_r.profile_length);
    end
  endtask

  // driver: next transaction goes out on the falling edge
  always @(negedge clk) begin
    if (!rst && (!start || taken)) begin
      if (pending_items.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        item <= pending_items.pop_front();
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: check results, predict accepted transactions, track the register
  always @(posedge clk) begin
    if (rst) begin
      taken <= 1'b0;
    end else begin
      if (done) begin
        if (expected_setpoints.size() == 0) begin
          report_mismatch("unexpected result", '0, result);
        end else begin
          if (result.setpoint !== expected_setpoints[0].setpoint ||
              result.profile_length !== expected_setpoints[0].profile_length) begin
            report_mismatch("result mismatch", expected_setpoints[0], result);
          end
          void'(expected_setpoints.pop_front());
        end
      end
      taken <= start && !busy;
      if (start && !busy) begin
        if (item.command == CMD_LOAD) begin
          if (item.segment_slot < MAX_SEGMENTS_DEF) begin
            profile_table[item.segment_slot] = '{kind: kind_t'(item.segment_kind),
                                                 length: item.segment_length,
                                                 goal: item.segment_goal};
          end
        end else begin
          expected_setpoints.push_back(predict_setpoint(item.query_time));
        end
      end
      if (config_write) active_segments = config_data;
    end
  end

  task automatic queue_load(input int unsigned slot, input int unsigned kind,
                            input int unsigned len, input int unsigned goal);
    item_t x;
    x.command        = CMD_LOAD;
    x.segment_slot   = SLOT_W'(slot);
    x.segment_kind   = KIND_W'(kind);
    x.segment_length = LEN_W'(len);
    x.segment_goal   = TEMP_W'(goal);
    x.query_time     = TIME_W'($urandom);
    pending_items.push_back(x);
    planned_length[slot] = len;
  endtask

  task automatic queue_query(input int unsigned t);
    item_t x;
    x.command        = CMD_QUERY;
    x.segment_slot   = SLOT_W'($urandom);
    x.segment_kind   = KIND_W'($urandom);
    x.segment_length = LEN_W'($urandom);
    x.segment_goal   = TEMP_W'($urandom);
    x.query_time     = TIME_W'(t);
    pending_items.push_back(x);
  endtask

  // let everything drain, then wait for a trailing load
  task automatic wait_drained();
    while (pending_items.size() != 0 || start || busy || expected_setpoints.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic program_count(input int unsigned n);
    wait_drained();
    @(negedge clk);
    config_write <= 1'b1;
    config_data  <= CNT_W'(n);
    @(negedge clk);
    config_write <= 1'b0;
    planned_count = n;
  endtask

  // stimulus
  initial begin
    int unsigned phase;
    int unsigned sub;
    int unsigned k;
    int unsigned n;
    int unsigned i;
    int unsigned total;
    int unsigned pick;
    int unsigned len;
    int unsigned t;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // no profile yet: start temperature and default length
    queue_query(0);
    queue_query(20'hFFFFF);

    // fill every slot: zero-length ramp, full-scale rise, hold, longest
    // falling ramp, step, unused kind, short truncating ramp, empty hold
    queue_load(0, KIND_RAMP, 0, 1000);
    queue_load(1, KIND_RAMP, 100, 8191);
    queue_load(2, KIND_HOLD, 50, 8191);
    queue_load(3, KIND_RAMP, 65535, 0);
    queue_load(4, KIND_STEP, 10, 500);
    queue_load(5, KIND_RSVD, 20, 700);
    queue_load(6, KIND_RAMP, 7, 703);
    queue_load(7, KIND_HOLD, 0, 0);

    program_count(8);
    queue_query(0);
    queue_query(37);
    queue_query(100);
    queue_query(150);
    queue_query(151);
    queue_query(30000);
    queue_query(65685);
    queue_query(65690);
    queue_query(65710);
    queue_query(65718);
    queue_query(65722);
    queue_query(65723);
    queue_query(20'hFFFFF);

    // count above the table depth saturates
    program_count(15);
    queue_query(20'hFFFFF);

    // one zero-length segment: past the end, default length
    program_count(1);
    queue_query(50);

    // random phases with a new segment count each time
    for (phase = 0; phase < 3; phase++) begin
      for (sub = 0; sub < 5; sub++) begin
        case (sub)
          0: n = 8;
          1: n = 15;
          2: n = 0;
          3: n = 1;
          default: n = $urandom_range(15);
        endcase
        program_count(n);
        sender_idle_pct = (phase == 0) ? 27 : (phase == 1) ? 48 : 0;
        for (k = 0; k < 80; k++) begin
          n = (planned_count > MAX_SEGMENTS_DEF) ? MAX_SEGMENTS_DEF : planned_count;
          total = 0;
          for (i = 0; i < n; i++) total += planned_length[i];
          if ($urandom_range(99) < 25) begin
            pick = $urandom_range(9);
            if (pick < 6) len = $urandom_range(300);
            else if (pick < 8) len = $urandom_range(3);
            else len = $urandom_range(16'hFFFF);
            queue_load($urandom_range(MAX_SEGMENTS_DEF - 1), $urandom_range(3), len,
                       $urandom_range(13'h1FFF));
          end else begin
            pick = $urandom_range(99);
            if (pick < 20) begin
              t = $urandom_range(20'hFFFFF);
            end else if (pick < 40) begin
              // on a segment boundary or just past it
              t = 0;
              for (i = 0; i < $urandom_range(n); i++) t += planned_length[i];
              t += $urandom_range(1);
            end else begin
              t = $urandom_range(total + total / 8 + 2);
            end
            queue_query(t);
          end
        end
      end
    end

    // drain and allow for the longest query
    wait_drained();
    repeat (64) @(posedge clk);
    if (mismatch_count == 0 && expected_setpoints.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // watchdog
  initial begin
    #1_500_000;
    $display("FAILURE");
    $finish;
  end

endmodule

@@ filelist.f @@
src/rhps_pkg.sv
src/rhps_ram.sv
src/rhps_seq.sv
src/rhps_dp.sv
src/ramp_hold_profile_setpoint.sv
tb/testbench.sv
